// ===== design/rlht_pkg.sv =====
// rlht_pkg: shared types and constants of the rate-limited heading tracker
// holds field widths, register indexes, turn codes and the cordic arctangent table
// no dependencies
`timescale 1ns / 1ps

package rlht_pkg;

	// fixed field widths of the channels
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned TICKS_W    = 24;
	localparam int unsigned ANGLE_W    = 32;
	localparam int unsigned DIR_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned RATE_W     = 24;

	// offsets enter the rotation scaled by 2^PRESCALE
	localparam int unsigned PRESCALE = 24;

	// angle constants in 2^-32 turn units
	localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [31:0] TURN_3QUART  = 32'hC000_0000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_TURN_RATE = 2'd2
	} cfg_reg_t;

	// turn direction codes
	typedef enum logic [DIR_W-1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} turn_dir_t;

	// atan(2^-i) in 2^-32 turn units, rounded to nearest
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== design/rlht_if.sv =====
// rlht channel interfaces: target request, heading result and register write
// depends on rlht_pkg for the field widths
`timescale 1ns / 1ps

interface rlht_in_if;
	import rlht_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] target_x;
	logic [COORD_W-1:0] target_y;
	logic [TICKS_W-1:0] elapsed_ticks;

	modport source (output valid, target_x, target_y, elapsed_ticks, input ready);
	modport sink   (input valid, target_x, target_y, elapsed_ticks, output ready);
endinterface

interface rlht_out_if;
	import rlht_pkg::*;
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] heading;
	logic [ANGLE_W-1:0] bearing;
	logic [DIR_W-1:0]   turn_dir;

	modport source (output valid, heading, bearing, turn_dir, input ready);
	modport sink   (input valid, heading, bearing, turn_dir, output ready);
endinterface

interface rlht_cfg_if;
	import rlht_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rate_limited_heading_tracker_top.sv =====
// rate_limited_heading_tracker_top: turns a stored heading toward a target bearing
// depends on rlht_pkg, rlht_if and rlht_cordic
`timescale 1ns / 1ps

// channel  dir  fields                                   accepted when
// in_ch    in   target_x, target_y, elapsed_ticks        valid && ready
// out_ch   out  heading, bearing, turn_dir               valid && ready
// cfg      in   index (0 center_x, 1 center_y, 2 rate)    valid && ready
//
// a request on an axis or at the centre gets its bearing from the cordic directly;
// otherwise the single cordic micro-rotation unit runs up to CORDIC_STEPS rotations,
// and it ends early once the residual y is zero
// in_ch.ready is high only while idle; a finished result waits in the output
// register, so the next request is taken while out_ch is stalled
// cfg is always ready; reset gives heading 0 and the register reset values

module rate_limited_heading_tracker_top #(
	parameter int unsigned ANGLE_BITS   = 32,
	parameter int unsigned COORD_BITS   = 12,
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	rlht_in_if.sink     in_ch,
	rlht_out_if.source  out_ch,
	rlht_cfg_if.sink    cfg
);
	import rlht_pkg::*;

	localparam int unsigned PROD_W = RATE_W + TICKS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN
	} state_t;

	state_t                  state_q;
	logic [COORD_W-1:0]      center_x_q;
	logic [COORD_W-1:0]      center_y_q;
	logic [RATE_W-1:0]       turn_rate_q;
	logic [ANGLE_BITS-1:0]   heading_q;
	logic [ANGLE_BITS-1:0]   step_q;

	logic                    out_valid_q;
	logic [ANGLE_W-1:0]      out_heading_q;
	logic [ANGLE_W-1:0]      out_bearing_q;
	turn_dir_t               out_dir_q;

	logic                    accept;
	logic [15:0]             tx_ext;
	logic [15:0]             ty_ext;
	logic [15:0]             cx_ext;
	logic [15:0]             cy_ext;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic [PROD_W-1:0]       prod;
	logic                    cordic_done;
	logic [31:0]             cordic_z;
	logic [ANGLE_BITS-1:0]   bearing;
	logic [ANGLE_BITS-1:0]   diff;
	logic                    out_free;
	logic                    out_load;
	turn_dir_t               dir;
	logic [ANGLE_BITS-1:0]   heading_nx;

	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	// offsets from the centre, coordinates cut to COORD_BITS
	assign tx_ext = 16'(in_ch.target_x);
	assign ty_ext = 16'(in_ch.target_y);
	assign cx_ext = 16'(center_x_q);
	assign cy_ext = 16'(center_y_q);
	assign dx = $signed({1'b0, tx_ext[COORD_BITS-1:0]}) - $signed({1'b0, cx_ext[COORD_BITS-1:0]});
	assign dy = $signed({1'b0, ty_ext[COORD_BITS-1:0]}) - $signed({1'b0, cy_ext[COORD_BITS-1:0]});

	// heading step, modulo a turn
	assign prod = PROD_W'(turn_rate_q) * PROD_W'(in_ch.elapsed_ticks);

	rlht_cordic #(
		.COORD_BITS  (COORD_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.dx     (dx),
		.dy     (dy),
		.done   (cordic_done),
		.bearing(cordic_z)
	);

	// turn decision on the modular difference
	assign bearing  = cordic_z[31 -: ANGLE_BITS];
	assign diff     = bearing - heading_q;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_load = (state_q == ST_FIN) && out_free;

	always_comb begin
		priority if (diff == '0) begin
			dir        = DIR_NONE;
			heading_nx = heading_q;
		end else if (!diff[ANGLE_BITS-1]) begin
			dir        = DIR_UP;
			heading_nx = heading_q + step_q;
		end else begin
			dir        = DIR_DOWN;
			heading_nx = heading_q - step_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= COORD_W'(400);
			center_y_q  <= COORD_W'(300);
			turn_rate_q <= RATE_W'(179);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X:  center_x_q  <= cfg.data[COORD_W-1:0];
				REG_CENTER_Y:  center_y_q  <= cfg.data[COORD_W-1:0];
				REG_TURN_RATE: turn_rate_q <= cfg.data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, heading state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= prod[ANGLE_BITS-1:0];
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (cordic_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						heading_q     <= heading_nx;
						out_heading_q <= ANGLE_W'(heading_nx);
						out_bearing_q <= ANGLE_W'(bearing);
						out_dir_q     <= dir;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.heading  = out_heading_q;
	assign out_ch.bearing  = out_bearing_q;
	assign out_ch.turn_dir = out_dir_q;

endmodule

// ===== design/rlht_cordic.sv =====
// rlht_cordic: iterative vectoring cordic, one micro-rotation per cycle
// gives the bearing of (dx, dy) in 2^-32 turn units; depends on rlht_pkg
`timescale 1ns / 1ps

module rlht_cordic #(
	parameter int unsigned COORD_BITS   = 12,
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [COORD_BITS:0]  dx,
	input  logic signed [COORD_BITS:0]  dy,
	output logic                        done,
	output logic [31:0]                 bearing
);
	import rlht_pkg::*;

	// room for sign, cordic gain and the prescale
	localparam int unsigned W  = COORD_BITS + PRESCALE + 3;
	localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_ROT
	} cstate_t;

	cstate_t               state_q;
	logic signed [W-1:0]   x_q;
	logic signed [W-1:0]   y_q;
	logic [31:0]           z_q;
	logic [CW-1:0]         i_q;
	logic                  done_q;

	logic signed [W-1:0]   ex;
	logic signed [W-1:0]   ey;
	logic signed [W-1:0]   x_sh;
	logic signed [W-1:0]   y_sh;
	logic [31:0]           atan_i;
	logic                  finish;
	logic                  trivial;

	// sign-extend and fold into the right half plane
	always_comb begin
		ex = W'(dx);
		ey = W'(dy);
		if (dx < 0) begin
			ex = -ex;
			ey = -ey;
		end
	end

	// shared shifter and table lookup for the current step
	assign x_sh    = x_q >>> i_q;
	assign y_sh    = y_q >>> i_q;
	assign atan_i  = atan_lut(5'(i_q));
	assign finish  = (y_q == '0) || (i_q == CW'(CORDIC_STEPS));
	assign trivial = (dx == 0) || (dy == 0);

	// sequencer and micro-rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
		end else begin
			done_q <= (state_q == ST_ROT) ? finish : (start && trivial);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q <= '0;
						x_q <= ex <<< PRESCALE;
						y_q <= ey <<< PRESCALE;
						priority if (dx == 0 && dy == 0) begin
							z_q <= '0;
						end else if (dy == 0) begin
							z_q <= (dx > 0) ? 32'd0 : TURN_HALF;
						end else if (dx == 0) begin
							z_q <= (dy > 0) ? TURN_QUARTER : TURN_3QUART;
						end else begin
							z_q     <= (dx < 0) ? TURN_HALF : 32'd0;
							state_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else begin
						if (!y_q[W-1]) begin
							x_q <= x_q + y_sh;
							y_q <= y_q - x_sh;
							z_q <= z_q + atan_i;
						end else begin
							x_q <= x_q - y_sh;
							y_q <= y_q + x_sh;
							z_q <= z_q - atan_i;
						end
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign bearing = z_q;

endmodule
